// ===== rtl/clr_pkg.sv =====
// ============================================================================
// clr_pkg: shared types and constants of the clipped line rasterizer
// Holds coordinate types, defaults for the grid size and the
// controller/datapath interface structs.
// ============================================================================
package clr_pkg;

    localparam int GRID_WIDTH_DEF  = 25;
    localparam int GRID_HEIGHT_DEF = 25;

    localparam int IN_COORD_W = 8;   // endpoint coordinate width
    localparam int COORD_W    = 10;  // walk coordinate width, holds -512 .. 511
    localparam int DELTA_W    = 9;   // absolute delta, 0 .. 255
    localparam int CNT_W      = 10;  // error counter, 0 .. 510
    localparam int PIX_W      = 5;   // output pixel coordinate
    localparam int FRAME_W    = 3;

    localparam int S_DATA_W = 40;    // 35 payload bits padded to bytes
    localparam int M_DATA_W = 16;    // 13 payload bits padded to bytes

    typedef logic signed [IN_COORD_W-1:0] in_coord_t;
    typedef logic signed [COORD_W-1:0]    coord_t;
    typedef logic [DELTA_W-1:0]           delta_t;
    typedef logic [CNT_W-1:0]             cnt_t;
    typedef logic [PIX_W-1:0]             pix_t;
    typedef logic [FRAME_W-1:0]           frame_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_FINISH
    } clr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the input transfer
        logic setup;   // compute deltas, axis choice and start point
        logic step;    // advance the walk by one major position
        logic finish;  // place the final result in the output register
    } clr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic reject;      // both endpoints at or past the far grid edge on one axis
        logic hit;         // current walk position lies on the grid
        logic pend_valid;  // a drawn pixel waits to be sent
        logic walk_done;   // current step is the last one of the walk
        logic out_free;    // output register can take a result this cycle
    } clr_status_t;

endpackage

// ===== rtl/clr_ctrl.sv =====
// ============================================================================
// clr_ctrl: controller of the clipped line rasterizer
// Sequences capture, setup, the pixel walk and the final result.
// ============================================================================
module clr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output clr_pkg::clr_cmd_t cmd,
    input  clr_pkg::clr_status_t st
);
    import clr_pkg::*;

    clr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = st.reject ? ST_FINISH : ST_WALK;
            end
            ST_WALK: begin
                if (cmd.step && st.walk_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (st.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SETUP: begin
                cmd.setup = 1'b1;
            end
            ST_WALK: begin
                // A new hit pushes the pending pixel out, so it needs room.
                cmd.step = !(st.hit && st.pend_valid) || st.out_free;
            end
            ST_FINISH: begin
                cmd.finish = st.out_free;
            end
            default: begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

    // A step that pushes a pending pixel never overwrites an unsent result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step && st.hit && st.pend_valid |-> st.out_free)
        else $error("clr_ctrl: step would overwrite the output register");

    // The final result is only loaded into a free output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> st.out_free)
        else $error("clr_ctrl: finish with a busy output register");

    // A rejected line goes straight to the final result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SETUP && st.reject |=> state_reg == ST_FINISH)
        else $error("clr_ctrl: rejected line entered the walk");

endmodule

// ===== rtl/clr_datapath.sv =====
// ============================================================================
// clr_datapath: datapath of the clipped line rasterizer
// Holds the line, the error counter, the pending pixel and the output
// register, and steps the walk one major position per command.
// ============================================================================
module clr_datapath #(
    parameter int GRID_WIDTH  = clr_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = clr_pkg::GRID_HEIGHT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [clr_pkg::S_DATA_W-1:0]  s_tdata,
    input  clr_pkg::clr_cmd_t             cmd,
    output clr_pkg::clr_status_t          st,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [clr_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import clr_pkg::*;

    localparam coord_t GW_S = coord_t'(GRID_WIDTH);
    localparam coord_t GH_S = coord_t'(GRID_HEIGHT);

    // Captured input.
    in_coord_t ax_reg, ay_reg, bx_reg, by_reg;
    frame_t    frame_reg;

    // Walk state.
    logic   xmajor_reg, step_pos_reg;
    coord_t maj_reg, min_reg;
    cnt_t   cnt_reg;
    delta_t dmaj_reg, dmin_reg, rem_reg;

    // Pending pixel and output register.
    logic pend_valid_reg;
    pix_t pend_x_reg, pend_y_reg;
    logic m_valid_reg, m_user_reg, m_last_reg;
    pix_t m_x_reg, m_y_reg;
    frame_t m_frame_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ax_reg    <= in_coord_t'(s_tdata[7:0]);
            ay_reg    <= in_coord_t'(s_tdata[15:8]);
            bx_reg    <= in_coord_t'(s_tdata[23:16]);
            by_reg    <= in_coord_t'(s_tdata[31:24]);
            frame_reg <= s_tdata[34:32];
        end
    end

    // ---------------- setup ----------------
    coord_t ax, ay, bx, by, diff_x, diff_y;
    coord_t sx_c, sy_c, ex_c, ey_c;
    delta_t dx_c, dy_c;
    logic   xmaj_c, keep_c, step_pos_c;

    always_comb begin
        ax     = coord_t'(ax_reg);
        ay     = coord_t'(ay_reg);
        bx     = coord_t'(bx_reg);
        by     = coord_t'(by_reg);
        diff_x = bx - ax;
        diff_y = by - ay;
        dx_c   = diff_x[COORD_W-1] ? delta_t'(-diff_x) : delta_t'(diff_x);
        dy_c   = diff_y[COORD_W-1] ? delta_t'(-diff_y) : delta_t'(diff_y);
        xmaj_c = dx_c > dy_c;
        keep_c = xmaj_c ? (bx > ax) : (by > ay);
        sx_c   = keep_c ? ax : bx;
        sy_c   = keep_c ? ay : by;
        ex_c   = keep_c ? bx : ax;
        ey_c   = keep_c ? by : ay;
        step_pos_c = xmaj_c ? (ey_c > sy_c) : (ex_c > sx_c);
    end

    assign st.reject = ((ax >= GW_S) && (bx >= GW_S)) || ((ay >= GH_S) && (by >= GH_S));

    // ---------------- walk step ----------------
    cnt_t   cnt_sum, cnt_new;
    logic   over;
    coord_t min_new, pix_x, pix_y, maj_inc;

    always_comb begin
        cnt_sum = cnt_reg + cnt_t'(dmin_reg);
        over    = cnt_sum > cnt_t'(dmaj_reg);
        cnt_new = over ? cnt_sum - cnt_t'(dmaj_reg) : cnt_sum;
        if (over) begin
            min_new = step_pos_reg ? min_reg + coord_t'(1) : min_reg - coord_t'(1);
        end else begin
            min_new = min_reg;
        end
        pix_x   = xmajor_reg ? maj_reg : min_new;
        pix_y   = xmajor_reg ? min_new : maj_reg;
        maj_inc = maj_reg + coord_t'(1);
    end

    assign st.hit = !pix_x[COORD_W-1] && (pix_x < GW_S) &&
                    !pix_y[COORD_W-1] && (pix_y < GH_S);
    assign st.walk_done = (rem_reg == '0) || (maj_inc >= (xmajor_reg ? GW_S : GH_S));
    assign st.pend_valid = pend_valid_reg;
    assign st.out_free   = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            xmajor_reg   <= xmaj_c;
            step_pos_reg <= step_pos_c;
            maj_reg      <= xmaj_c ? sx_c : sy_c;
            min_reg      <= xmaj_c ? sy_c : sx_c;
            dmaj_reg     <= xmaj_c ? dx_c : dy_c;
            dmin_reg     <= xmaj_c ? dy_c : dx_c;
            rem_reg      <= xmaj_c ? dx_c : dy_c;
            cnt_reg      <= '0;
        end else if (cmd.step) begin
            maj_reg <= maj_inc;
            min_reg <= min_new;
            cnt_reg <= cnt_new;
            rem_reg <= rem_reg - delta_t'(1);
        end
    end

    // ---------------- pending pixel ----------------
    logic pend_valid_next;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        if (cmd.setup || cmd.finish) begin
            pend_valid_next = 1'b0;
        end else if (cmd.step && st.hit) begin
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step && st.hit) begin
            pend_x_reg <= pix_x[PIX_W-1:0];
            pend_y_reg <= pix_y[PIX_W-1:0];
        end
    end

    // ---------------- output register ----------------
    logic out_load, m_valid_next;

    assign out_load = (cmd.step && st.hit && pend_valid_reg) || cmd.finish;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_frame_reg <= frame_reg;
            m_last_reg  <= cmd.finish;
            m_user_reg  <= pend_valid_reg;
            // An empty line sends a single result with zero coordinates.
            m_x_reg     <= pend_valid_reg ? pend_x_reg : '0;
            m_y_reg     <= pend_valid_reg ? pend_y_reg : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_DATA_W - 2*PIX_W - FRAME_W){1'b0}}, m_frame_reg, m_y_reg, m_x_reg};

    // A result without a drawn pixel is always the last one of its line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_user_reg |-> m_last_reg)
        else $error("clr_datapath: empty result not marked last");

    // A pushed pending pixel is replaced in the same cycle by the new hit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step && st.hit |=> pend_valid_reg)
        else $error("clr_datapath: hit did not become pending");

endmodule

// ===== rtl/clipped_line_rasterizer.sv =====
// ============================================================================
// clipped_line_rasterizer: clipped Bresenham line walker
// Turns one line command into the stream of on-grid pixels of that line.
// ============================================================================
// Usage: the slave channel takes one line per transfer (two signed
// endpoints and a frame plane). The master channel returns one transfer per
// drawn pixel in walk order; tlast marks the final pixel of the line. A line
// that draws nothing returns exactly one transfer with tuser low, tlast high
// and zero coordinates.
// Timing: a line is captured in the idle state and then set up. The walk
// then covers one major position per cycle while the output has room, for
// at most |major delta| + 1 positions and stopping once the major
// coordinate leaves the grid. The finish state then places the final
// result. A line rejected outright skips the walk and goes from setup
// straight to the final result.
// The walk is the limiting loop: one error-counter update per unstalled cycle.
// s_tready is high only between lines; the next line is accepted while the
// final result of the previous one still waits in the output register.
// Stall: when the receiver holds tready low, the walk pauses at the next
// drawn pixel, because one pixel is held back to learn whether it is last.
// Reset: aresetn (synchronous, active low) returns the controller to idle
// and drops any pending pixel and result.
// ============================================================================
module clipped_line_rasterizer #(
    parameter int GRID_WIDTH  = clr_pkg::GRID_WIDTH_DEF,   // 1 .. 32
    parameter int GRID_HEIGHT = clr_pkg::GRID_HEIGHT_DEF   // 1 .. 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Line command.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_x[7:0], start_y[15:8], end_x[23:16], end_y[31:24],
    // frame_select[34:32], zero fill above.
    input  logic [clr_pkg::S_DATA_W-1:0]  s_tdata,
    // Pixel results.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pixel_x[4:0], pixel_y[9:5], frame_out[12:10], zero fill above.
    output logic [clr_pkg::M_DATA_W-1:0]  m_tdata,
    // pixel_valid[0]: high for a drawn pixel.
    output logic                          m_tuser,
    // last_pixel: final result of the line.
    output logic                          m_tlast
);
    import clr_pkg::*;

    clr_cmd_t    cmd;
    clr_status_t st;

    // The controller only sequences; all line arithmetic sits in the datapath.
    clr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .st       (st)
    );

    clr_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/clipped_line_rasterizer_test.sv =====
// ============================================================================
// clipped_line_rasterizer_test: self-checking testbench of the line rasterizer
// Sends line commands on the slave stream and checks every pixel transfer on
// the master stream against a line walker built into the bench. Directed
// lines come first, then random lines, with bursty input and a stalling
// receiver.
// ============================================================================
module clipped_line_rasterizer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import clr_pkg::*;

    localparam int GRID_W      = 25;
    localparam int GRID_H      = 25;
    localparam int RANDOM_LINES = 260;
    // A walk can run long without drawing a pixel, and the receiver can
    // stall for a while on top of that; this is several times the worst
    // quiet stretch of a correct run.
    localparam int IDLE_LIMIT  = 3000;
    // Cycles to wait at the end for any stray pixel transfer.
    localparam int TAIL_CYCLES = 300;

    // One line command as it travels on the slave stream.
    typedef struct {
        in_coord_t sx;
        in_coord_t sy;
        in_coord_t ex;
        in_coord_t ey;
        frame_t    frame;
        bit        drain;  // hold this line back until every pixel has come
    } line_cmd_t;

    // One pixel transfer as it should appear on the master stream.
    typedef struct {
        pix_t   x;
        pix_t   y;
        frame_t frame;
        logic   drawn;
        logic   last;
    } pixel_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    line_cmd_t pending_lines[$];
    pixel_t    expected_pixels[$];
    line_cmd_t line_on_bus;
    int        error_count = 0;

    clipped_line_rasterizer #(
        .GRID_WIDTH (GRID_W),
        .GRID_HEIGHT(GRID_H)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // 4 ns clock.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Prints one line for a failed check and counts it.
    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Walks one line the way the block does and queues the pixel transfers
    // it must produce. The error counter adds the minor delta before each
    // pixel test, with no half offset, and the walk stops once the major
    // coordinate leaves the grid.
    function automatic void predict_line_pixels(line_cmd_t cmd);
        int     ax, ay, bx, by;
        int     dx, dy, dmaj, dmin, err, step, cx, cy;
        bit     xmajor, keep;
        pixel_t drawn_pixels[$];
        pixel_t pix;
        ax = cmd.sx;
        ay = cmd.sy;
        bx = cmd.ex;
        by = cmd.ey;
        // A line whose endpoints both lie past the far edge of one axis is
        // rejected without a walk.
        if (!((ax >= GRID_W && bx >= GRID_W) || (ay >= GRID_H && by >= GRID_H))) begin
            dx     = (bx > ax) ? bx - ax : ax - bx;
            dy     = (by > ay) ? by - ay : ay - by;
            xmajor = dx > dy;  // equal deltas walk along y
            keep   = xmajor ? (bx > ax) : (by > ay);
            dmaj   = xmajor ? dx : dy;
            dmin   = xmajor ? dy : dx;
            cx     = keep ? ax : bx;
            cy     = keep ? ay : by;
            if (xmajor) begin
                step = ((keep ? by : ay) > cy) ? 1 : -1;
            end else begin
                step = ((keep ? bx : ax) > cx) ? 1 : -1;
            end
            err = 0;
            for (int i = 0; i <= dmaj; i++) begin
                err += dmin;
                if (err > dmaj) begin
                    err -= dmaj;
                    if (xmajor) begin
                        cy += step;
                    end else begin
                        cx += step;
                    end
                end
                if (cx >= 0 && cx < GRID_W && cy >= 0 && cy < GRID_H &&
                    drawn_pixels.size() < 32) begin
                    pix.x     = pix_t'(cx);
                    pix.y     = pix_t'(cy);
                    pix.frame = cmd.frame;
                    pix.drawn = 1'b1;
                    pix.last  = 1'b0;
                    drawn_pixels.push_back(pix);
                end
                if (xmajor) begin
                    cx++;
                    if (cx >= GRID_W) break;
                end else begin
                    cy++;
                    if (cy >= GRID_H) break;
                end
            end
        end
        // A line that draws nothing still answers with one empty transfer.
        if (drawn_pixels.size() == 0) begin
            pix.x     = '0;
            pix.y     = '0;
            pix.frame = cmd.frame;
            pix.drawn = 1'b0;
            pix.last  = 1'b0;
            drawn_pixels.push_back(pix);
        end
        drawn_pixels[drawn_pixels.size()-1].last = 1'b1;
        foreach (drawn_pixels[k]) expected_pixels.push_back(drawn_pixels[k]);
    endfunction

    // Most random endpoints sit on or just around the grid so that lines
    // are clipped at every edge; the rest span the whole signed range or hit its extremes and the grid edges.
    function automatic in_coord_t pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return in_coord_t'(int'($urandom_range(0, 40)) - 8);
        end else if (r < 85) begin
            return in_coord_t'($urandom_range(0, 255));
        end else begin
            case ($urandom_range(0, 5))
                0:       return in_coord_t'(-128);
                1:       return in_coord_t'(-1);
                2:       return in_coord_t'(0);
                3:       return in_coord_t'(GRID_W - 1);
                4:       return in_coord_t'(GRID_W);
                default: return in_coord_t'(127);
            endcase
        end
    endfunction

    function automatic line_cmd_t make_line(int sx, int sy, int ex, int ey, int frame,
                                            bit drain);
        line_cmd_t cmd;
        cmd.sx    = in_coord_t'(sx);
        cmd.sy    = in_coord_t'(sy);
        cmd.ex    = in_coord_t'(ex);
        cmd.ey    = in_coord_t'(ey);
        cmd.frame = frame_t'(frame);
        cmd.drain = drain;
        return cmd;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents queued lines in bursts of random length separated by
    // random gaps. A line marked for draining waits until the block has
    // delivered every pixel it owes. The line is predicted at the edge that
    // completes its transfer.
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_line_pixels(line_on_bus);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_lines.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (pending_lines[0].drain && expected_pixels.size() != 0) begin
                    s_tvalid <= 1'b0;
                end else begin
                    line_on_bus = pending_lines.pop_front();
                    s_tdata  <= {5'b0, line_on_bus.frame, line_on_bus.ey, line_on_bus.ex,
                                 line_on_bus.sy, line_on_bus.sx};
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 8);
                        // About a third of the bursts run straight into the
                        // next one with no gap at all.
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks every pixel transfer against the oldest expectation.
    // Each time its phase counter wraps, the receiver picks a new stall behavior
    // among always ready, coin flips, mostly stalled and a fixed one-in-four stall.
    // ------------------------------------------------------------------------
    int     stall_mode  = 0;
    int     stall_phase = 0;
    pixel_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    report_error($sformatf("unexpected pixel transfer x=%0d y=%0d",
                                           m_tdata[4:0], m_tdata[9:5]));
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_tdata[4:0] !== want.x)
                        report_error($sformatf("pixel_x got %0d want %0d",
                                               m_tdata[4:0], want.x));
                    if (m_tdata[9:5] !== want.y)
                        report_error($sformatf("pixel_y got %0d want %0d",
                                               m_tdata[9:5], want.y));
                    if (m_tdata[12:10] !== want.frame)
                        report_error($sformatf("frame_out got %0d want %0d",
                                               m_tdata[12:10], want.frame));
                    if (m_tuser !== want.drawn)
                        report_error($sformatf("pixel_valid got %b want %b",
                                               m_tuser, want.drawn));
                    if (m_tlast !== want.last)
                        report_error($sformatf("last_pixel got %b want %b",
                                               m_tlast, want.last));
                end
            end
            stall_phase++;
            if (stall_phase >= 48) begin
                stall_phase = 0;
                stall_mode  = $urandom_range(0, 3);
            end
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((stall_phase % 4) != 3);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when no transfer happens on either stream for
    // too long.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
                $display("clipped_line_rasterizer_test: errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin
        line_cmd_t cmd;

        // Directed lines: single points, the four straight directions, both
        // diagonals with equal deltas, rejection on each axis, lines that
        // fall entirely off the grid, and the extremes of the signed range.
        pending_lines.push_back(make_line(0, 0, 0, 0, 0, 0));
        pending_lines.push_back(make_line(24, 24, 24, 24, 7, 0));
        pending_lines.push_back(make_line(0, 5, 24, 5, 1, 0));
        pending_lines.push_back(make_line(24, 7, 0, 7, 2, 0));
        pending_lines.push_back(make_line(3, 0, 3, 24, 3, 0));
        pending_lines.push_back(make_line(3, 24, 3, 0, 4, 0));
        pending_lines.push_back(make_line(0, 0, 20, 20, 5, 0));
        pending_lines.push_back(make_line(20, 0, 0, 20, 6, 0));
        pending_lines.push_back(make_line(25, 0, 127, 24, 7, 0));
        pending_lines.push_back(make_line(0, 30, 10, 25, 1, 0));
        pending_lines.push_back(make_line(30, 3, 30, 3, 2, 0));
        pending_lines.push_back(make_line(-1, 0, -1, 0, 3, 0));
        pending_lines.push_back(make_line(-10, -10, -1, -5, 4, 0));
        pending_lines.push_back(make_line(-128, -128, 127, 127, 5, 0));
        pending_lines.push_back(make_line(127, -128, -128, 127, 6, 0));
        pending_lines.push_back(make_line(-128, 127, 127, -128, 0, 0));
        pending_lines.push_back(make_line(-128, 3, 10, 4, 7, 0));
        pending_lines.push_back(make_line(0, -128, 24, 127, 1, 0));
        pending_lines.push_back(make_line(0, 0, 24, 3, 2, 0));
        pending_lines.push_back(make_line(0, 0, 3, 24, 3, 0));
        pending_lines.push_back(make_line(24, 1, 2, 23, 4, 0));

        // Random lines; every seventieth one waits for the block to drain.
        for (int i = 0; i < RANDOM_LINES; i++) begin
            cmd.sx    = pick_coord();
            cmd.sy    = pick_coord();
            cmd.ex    = pick_coord();
            cmd.ey    = pick_coord();
            cmd.frame = frame_t'($urandom_range(0, 7));
            cmd.drain = (i % 70 == 0);
            pending_lines.push_back(cmd);
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for the last line to be taken, then for its pixels, then for
        // a full walk time in case anything stray comes out.
        while (pending_lines.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (expected_pixels.size() != 0)
            report_error($sformatf("%0d pixel transfers never arrived",
                                   expected_pixels.size()));
        if (error_count == 0) begin
            $display("clipped_line_rasterizer_test: clean");
        end else begin
            $display("clipped_line_rasterizer_test: errors");
        end
        $finish;
    end

endmodule
